/* sv/baro_pressure_temp_compensation_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_TOP_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_TOP_MACROS_SVH

// same-cycle implication
`define BPTC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPTC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bptc_pkg.sv */
// ----------------------------------------------------------------------------
// bptc_pkg
// Widths, constants and the calibration coefficient type of the barometer
// compensation block.
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int unsigned RAW_W    = 24;
  localparam int unsigned TEMP_W   = 17;
  localparam int unsigned PRES_W   = 32;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned STAGES   = 16;

  localparam logic [1:0] REG_CAL_LOW  = 2'd0;
  localparam logic [1:0] REG_CAL_MID  = 2'd1;
  localparam logic [1:0] REG_CAL_HIGH = 2'd2;

  localparam logic [31:0] RAW_MID    = 32'd8388608;
  localparam logic [31:0] TEMP_BIAS  = 32'd81920000;  // 2500 << 15
  localparam logic [31:0] CF_BIAS    = 32'd2097152;
  localparam logic [31:0] PRES_BIAS  = 32'd99880;
  localparam logic [31:0] LOW11_MASK = 32'h0000_07FF;

  localparam logic [13:0] C1_OFS  = 14'd4459;
  localparam logic [9:0]  C2_OFS  = 10'd256;
  localparam logic [18:0] C4_OFS  = 19'd120586;
  localparam logic [15:0] C5_OFS  = 16'd4443;
  localparam logic [19:0] C7_OFS  = 20'd166426;
  localparam logic [13:0] C8_OFS  = 14'd7180;

  typedef struct packed {
    logic        [15:0] c0s;  // c0 << 4
    logic        [13:0] a1;   // c1 + 4459
    logic signed [9:0]  a2;   // c2 - 256
    logic        [12:0] c3;
    logic        [22:0] c4p;  // (c4 + 120586) << 4
    logic signed [15:0] a5;   // c5 - 4443
    logic        [12:0] c6;
    logic        [13:0] a8;   // c8 + 7180
    logic        [13:0] c9;
    logic        [19:0] k7;   // c7 + 166426
    logic        [9:0]  c10;
    logic        [7:0]  c11;
    logic        [4:0]  c12;
  } coef_t;

endpackage

/* sv/bptc_if.sv */
// ----------------------------------------------------------------------------
// bptc_in_if / bptc_out_if
// Valid/ready channels for raw readings and compensated results.
// ----------------------------------------------------------------------------
interface bptc_in_if import bptc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bptc_out_if import bptc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centideg;
  logic signed [PRES_W-1:0] pressure_pa;

  modport source (output valid, temperature_centideg, pressure_pa, input ready);
  modport sink   (input valid, temperature_centideg, pressure_pa, output ready);
endinterface

/* sv/bptc_pipe.sv */
// ----------------------------------------------------------------------------
// bptc_pipe
// Sixteen-stage compensation datapath with per-stage valid bits and
// bubble-collapsing flow control.
// ----------------------------------------------------------------------------
`include "baro_pressure_temp_compensation_top_macros.svh"

module bptc_pipe import bptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  coef_t       coef_i,
  bptc_in_if.sink     raw_i,
  bptc_out_if.source  res_o
);

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

  logic [STAGES-1:0] v_q;
  logic [STAGES-1:0] rdy;
  logic              acc_in;
  logic              acc_out;

  logic [RAW_W-1:0]  up_s0_q, ut_s0_q;
  logic [31:0]       dt_s1_q, pd_s1_q;
  logic [31:0]       p01_s2_q, p2a_s2_q, p3a_s2_q, dt_s2_q, pd_s2_q;
  logic [31:0]       x01_s3_q, p02_s3_q, p3b_s3_q, dt_s3_q, pd_s3_q;
  logic [31:0]       x01_s4_q, x02_s4_q, p03_s4_q, pd_s4_q;
  logic [31:0]       dt2_s5_q, pd_s5_q;
  logic [31:0]       p11_s6_q, p12a_s6_q, p21_s6_q, p22a_s6_q, pcf_s6_q;
  logic [31:0]       dt2_s6_q, pd_s6_q;
  logic [31:0]       x11_s7_q, p12_s7_q, x21_s7_q, p22_s7_q, cf_s7_q, pd_s7_q;
  logic [31:0]       x13_s8_q, x23_s8_q, p31a_s8_q, p32a_s8_q, pd_s8_q;
  logic              ge_s8_q, ge_s9_q;
  logic [31:0]       pp1_s9_q, p24_s9_q, p25_s9_q, t31_s9_q, t32a_s9_q;
  logic [31:0]       x26_s10_q, pp1_s10_q, t31_s10_q, t32a_s10_q;
  logic [31:0]       pp2_s11_q, pp3_s11_q, t31_s11_q, t32a_s11_q;
  logic [31:0]       pp4_s12_q, t31_s12_q, t32a_s12_q;
  logic [31:0]       p31_s13_q, p32b_s13_q, pp4_s13_q;
  logic [31:0]       x31_s14_q, p32_s14_q, pp4_s14_q;
  logic [31:0]       rp_s15_q;
  logic [TEMP_W-1:0] rt_s5_q, rt_s6_q, rt_s7_q, rt_s8_q, rt_s9_q, rt_s10_q;
  logic [TEMP_W-1:0] rt_s11_q, rt_s12_q, rt_s13_q, rt_s14_q, rt_s15_q;

  logic [31:0] sum_s4, diff_s4;
  logic [31:0] x12_s7, x22_s7;
  logic        ge_s7;
  logic [31:0] x25_s9, x26_s9;

  // a stage may load when res_o is ready or any stage from it onward holds a bubble
  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      rdy[k] = res_o.ready | (|(~v_q >> k));
    end
  end

  assign raw_i.ready = rdy[0];
  assign acc_in      = raw_i.valid && raw_i.ready;
  assign acc_out     = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= raw_i.valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    sum_s4  = x01_s4_q + x02_s4_q + p03_s4_q;
    diff_s4 = TEMP_BIAS - sum_s4;
    x12_s7  = asr(p12_s7_q, 2);
    x22_s7  = asr(p22_s7_q, 12);
    ge_s7   = $signed(x21_s7_q) >= $signed(x22_s7);
    x25_s9  = asr(p25_s9_q, 11);
    if (ge_s9_q) begin
      x26_s9 = asr(32'd0 - p24_s9_q - x25_s9, 11) + 32'(coef_i.k7);
    end else begin
      x26_s9 = asr(p24_s9_q + x25_s9, 11) + 32'(coef_i.k7);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      up_s0_q <= raw_i.raw_pressure;
      ut_s0_q <= raw_i.raw_temperature;
    end
    if (rdy[1]) begin
      dt_s1_q <= asr(32'(ut_s0_q) - RAW_MID, 4) + 32'(coef_i.c0s);
      pd_s1_q <= 32'(up_s0_q) - RAW_MID;
    end
    if (rdy[2]) begin
      p01_s2_q <= 32'(coef_i.a1) * dt_s1_q;
      p2a_s2_q <= 32'(coef_i.a2) * dt_s1_q;
      p3a_s2_q <= 32'(coef_i.c3) * dt_s1_q;
      dt_s2_q  <= dt_s1_q;
      pd_s2_q  <= pd_s1_q;
    end
    if (rdy[3]) begin
      x01_s3_q <= asr(p01_s2_q, 1);
      p02_s3_q <= asr(p2a_s2_q, 14) * dt_s2_q;
      p3b_s3_q <= asr(p3a_s2_q, 18) * dt_s2_q;
      dt_s3_q  <= dt_s2_q;
      pd_s3_q  <= pd_s2_q;
    end
    if (rdy[4]) begin
      x01_s4_q <= x01_s3_q;
      x02_s4_q <= asr(p02_s3_q, 4);
      p03_s4_q <= asr(p3b_s3_q, 18) * dt_s3_q;
      pd_s4_q  <= pd_s3_q;
    end
    if (rdy[5]) begin
      rt_s5_q  <= diff_s4[31:15];
      dt2_s5_q <= asr(sum_s4, 12);
      pd_s5_q  <= pd_s4_q;
    end
    if (rdy[6]) begin
      p11_s6_q  <= 32'(coef_i.a5) * dt2_s5_q;
      p12a_s6_q <= 32'(coef_i.c6) * dt2_s5_q;
      p21_s6_q  <= 32'(coef_i.a8) * dt2_s5_q;
      p22a_s6_q <= 32'(coef_i.c9) * dt2_s5_q;
      pcf_s6_q  <= 32'(coef_i.c12) * dt2_s5_q;
      dt2_s6_q  <= dt2_s5_q;
      rt_s6_q   <= rt_s5_q;
      pd_s6_q   <= pd_s5_q;
    end
    if (rdy[7]) begin
      x11_s7_q <= p11_s6_q;
      p12_s7_q <= asr(p12a_s6_q, 16) * dt2_s6_q;
      x21_s7_q <= asr(p21_s6_q, 10);
      p22_s7_q <= asr(p22a_s6_q, 17) * dt2_s6_q;
      cf_s7_q  <= asr(CF_BIAS + pcf_s6_q, 3);
      rt_s7_q  <= rt_s6_q;
      pd_s7_q  <= pd_s6_q;
    end
    if (rdy[8]) begin
      x13_s8_q  <= asr(x11_s7_q + x12_s7, 10) + 32'(coef_i.c4p);
      x23_s8_q  <= ge_s7 ? (x21_s7_q - x22_s7) : (x22_s7 - x21_s7_q);
      ge_s8_q   <= ge_s7;
      p31a_s8_q <= cf_s7_q * 32'(coef_i.c10);
      p32a_s8_q <= cf_s7_q * 32'(coef_i.c11);
      rt_s8_q   <= rt_s7_q;
      pd_s8_q   <= pd_s7_q;
    end
    if (rdy[9]) begin
      pp1_s9_q  <= asr(pd_s8_q - x13_s8_q, 3);
      p24_s9_q  <= asr(x23_s8_q, 11) * 32'(coef_i.k7);
      p25_s9_q  <= (x23_s8_q & LOW11_MASK) * 32'(coef_i.k7);
      ge_s9_q   <= ge_s8_q;
      t31_s9_q  <= asr(p31a_s8_q, 17);
      t32a_s9_q <= asr(p32a_s8_q, 15);
      rt_s9_q   <= rt_s8_q;
    end
    if (rdy[10]) begin
      x26_s10_q  <= x26_s9;
      pp1_s10_q  <= pp1_s9_q;
      t31_s10_q  <= t31_s9_q;
      t32a_s10_q <= t32a_s9_q;
      rt_s10_q   <= rt_s9_q;
    end
    if (rdy[11]) begin
      pp2_s11_q  <= asr(x26_s10_q, 11) * pp1_s10_q;
      pp3_s11_q  <= (x26_s10_q & LOW11_MASK) * pp1_s10_q;
      t31_s11_q  <= t31_s10_q;
      t32a_s11_q <= t32a_s10_q;
      rt_s11_q   <= rt_s10_q;
    end
    if (rdy[12]) begin
      pp4_s12_q  <= asr(pp2_s11_q + asr(pp3_s11_q, 11), 10);
      t31_s12_q  <= t31_s11_q;
      t32a_s12_q <= t32a_s11_q;
      rt_s12_q   <= rt_s11_q;
    end
    if (rdy[13]) begin
      p31_s13_q  <= t31_s12_q * pp4_s12_q;
      p32b_s13_q <= t32a_s12_q * pp4_s12_q;
      pp4_s13_q  <= pp4_s12_q;
      rt_s13_q   <= rt_s12_q;
    end
    if (rdy[14]) begin
      x31_s14_q <= asr(p31_s13_q, 2);
      p32_s14_q <= asr(p32b_s13_q, 18) * pp4_s13_q;
      pp4_s14_q <= pp4_s13_q;
      rt_s14_q  <= rt_s13_q;
    end
    if (rdy[15]) begin
      rp_s15_q <= asr(x31_s14_q + p32_s14_q, 15) + pp4_s14_q + PRES_BIAS;
      rt_s15_q <= rt_s14_q;
    end
  end

  assign res_o.valid                = v_q[STAGES-1];
  assign res_o.temperature_centideg = $signed(rt_s15_q);
  assign res_o.pressure_pa          = $signed(rp_s15_q);

  `BPTC_ASSERT_IMP(a_in_ready_when_out_ready, res_o.ready, raw_i.ready, "input stalled with output free")
  `BPTC_ASSERT_IMP(a_full_stall, (&v_q) && !res_o.ready, !raw_i.ready, "word accepted into full pipe")
  `BPTC_ASSERT_NXT(a_fill, acc_in && !acc_out, $countones(v_q) == $past($countones(v_q)) + 1, "word count did not grow")
  `BPTC_ASSERT_NXT(a_drain, acc_out && !acc_in, $countones(v_q) + 1 == $past($countones(v_q)), "word count did not shrink")
  `BPTC_ASSERT_NXT(a_hold_s14, v_q[14] && !rdy[15], v_q[14] && $stable(x31_s14_q), "stalled stage lost its word")

endmodule

/* sv/baro_pressure_temp_compensation_top.sv */
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top
// Barometer compensation: raw pressure and temperature in, temperature in
// centidegrees and pressure in pascals out, from packed calibration words.
//
//   channel | direction | protocol    | payload
//   raw_i   | in        | valid/ready | raw_pressure, raw_temperature
//   res_o   | out       | valid/ready | temperature_centideg, pressure_pa
//   apb     | in        | APB write   | cal_words_low/mid/high at 0x00/0x08/0x10
//
// One word per cycle while res_o takes results or a stage holds a bubble.
// The datapath has sixteen register stages, one 32-bit multiply per stage
// on the longest chain.
// Reset clears the calibration registers and all stage valid bits.
// raw_i.ready drops only when all sixteen stages hold words and res_o stalls.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_top import bptc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready,
  bptc_in_if.sink           raw_i,
  bptc_out_if.source        res_o
);

  logic [63:0] cal_low_q, cal_mid_q;
  logic [31:0] cal_high_q;
  logic [1:0]  reg_idx;
  logic        wr_en;
  coef_t       coef_d, coef_q;
  logic [15:0] r0, r1, r2, r3, r4, r5, r6, r7, r8, r9;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_low_q  <= '0;
      cal_mid_q  <= '0;
      cal_high_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CAL_LOW:  cal_low_q  <= pwdata;
        REG_CAL_MID:  cal_mid_q  <= pwdata;
        REG_CAL_HIGH: cal_high_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CAL_LOW:  prdata = cal_low_q;
      REG_CAL_MID:  prdata = cal_mid_q;
      REG_CAL_HIGH: prdata = {32'd0, cal_high_q};
      default:      prdata = '0;
    endcase
  end

  assign {r3, r2, r1, r0} = cal_low_q;
  assign {r7, r6, r5, r4} = cal_mid_q;
  assign {r9, r8}         = cal_high_q;

  always_comb begin
    coef_d.c0s = {r0[15:4], 4'd0};
    coef_d.a1  = 14'({r1[15:8], r2[2:0]}) + C1_OFS;
    coef_d.a2  = $signed(10'({r1[7:0], r4[0]}) - C2_OFS);
    coef_d.c3  = r2[15:3];
    coef_d.c4p = {19'({r3, r0[1:0]}) + C4_OFS, 4'd0};
    coef_d.a5  = $signed(16'(r4[15:1]) - C5_OFS);
    coef_d.c6  = r5[15:3];
    coef_d.a8  = 14'(r7[15:3]) + C8_OFS;
    coef_d.c9  = r8[15:2];
    coef_d.k7  = 20'({r6, r5[2:0]}) + C7_OFS;
    coef_d.c10 = {r9[15:8], r8[1:0]};
    coef_d.c11 = r9[7:0];
    coef_d.c12 = {r0[3:2], r7[2:0]};
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  bptc_pipe u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef_q),
    .raw_i  (raw_i),
    .res_o  (res_o)
  );

endmodule

/* test/baro_pressure_temp_compensation_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barometer compensation testbench
// Loads calibration words over APB, then streams raw pressure and
// temperature words and checks every compensated result against a
// fixed-point predictor kept in step with the calibration registers.
// Covers raw and calibration extremes, the unused register address, the
// ignored upper register bits, random readings and random handshake stalls.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_top_test import bptc_pkg::*; ();

  localparam logic [1:0]  CAL_UNUSED  = 2'd3;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          ITEMS_PER_SETTING = 140;

  localparam logic [31:0] READING_MID = 32'd8388608;
  localparam logic [31:0] K1_OFS      = 32'd4459;
  localparam logic [31:0] K2_OFS      = 32'd256;
  localparam logic [31:0] K4_OFS      = 32'd120586;
  localparam logic [31:0] K5_OFS      = 32'd4443;
  localparam logic [31:0] K7_OFS      = 32'd166426;
  localparam logic [31:0] K8_OFS      = 32'd7180;
  localparam logic [31:0] TEMP_REF    = 32'd2500;
  localparam logic [31:0] CORR_BIAS   = 32'd2097152;
  localparam logic [31:0] SEA_LEVEL   = 32'd99880;
  localparam logic [31:0] FRAC11      = 32'h7FF;

  localparam logic [63:0] CAL_LO_TYP  = 64'h6A3E_4D21_7B19_9A5C;
  localparam logic [63:0] CAL_MID_TYP = 64'h5C8F_3E21_4A67_2B3D;
  localparam logic [31:0] CAL_HI_TYP  = 32'h2D9C_71A4;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_cd;
    logic [PRES_W-1:0] pres_pa;
  } comp_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [CFG_W-1:0]  pwdata;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  bptc_in_if  raw_if ();
  bptc_out_if res_if ();

  baro_pressure_temp_compensation_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .raw_i   (raw_if),
    .res_o   (res_if)
  );

  logic [63:0]  cal_lo;
  logic [63:0]  cal_mid;
  logic [31:0]  cal_hi;
  comp_result_t expected_comp[$];
  int           src_idle_pct;
  int           snk_idle_pct;
  int           mismatches = 0;
  int           results_checked = 0;
  int           cal_settings;
  int           cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic comp_result_t compensate(input logic [RAW_W-1:0] p_raw,
                                              input logic [RAW_W-1:0] t_raw);
    logic [31:0]  w [10];
    logic [31:0]  k [13];
    logic [31:0]  up, ut, dtemp, t1, t2, t3, tcomp, dtq;
    logic [31:0]  off1, off2, offset, s1, s2, sdiff, sgain, s3, s4, sens;
    logic [31:0]  pa, pb, pc, pd, corr, q1, q2, pres;
    comp_result_t r;
    for (int i = 0; i < 10; i++) begin
      if (i < 4) w[i] = {16'd0, cal_lo[16*i +: 16]};
      else if (i < 8) w[i] = {16'd0, cal_mid[16*(i-4) +: 16]};
      else w[i] = {16'd0, cal_hi[16*(i-8) +: 16]};
    end
    k[0]  = w[0] >> 4;
    k[1]  = ((w[1] & 32'hFF00) >> 5) | (w[2] & 32'd7);
    k[2]  = ((w[1] & 32'h00FF) << 1) | (w[4] & 32'd1);
    k[3]  = w[2] >> 3;
    k[4]  = (w[3] << 2) | (w[0] & 32'd3);
    k[5]  = w[4] >> 1;
    k[6]  = w[5] >> 3;
    k[7]  = (w[6] << 3) | (w[5] & 32'd7);
    k[8]  = w[7] >> 3;
    k[9]  = w[8] >> 2;
    k[10] = ((w[9] & 32'hFF00) >> 6) | (w[8] & 32'd3);
    k[11] = w[9] & 32'h00FF;
    k[12] = ((w[0] & 32'h000C) << 1) | (w[7] & 32'd7);

    up = {8'd0, p_raw};
    ut = {8'd0, t_raw};

    dtemp = asr(ut - READING_MID, 4) + (k[0] << 4);
    t1    = asr((k[1] + K1_OFS) * dtemp, 1);
    t2    = asr(asr((k[2] - K2_OFS) * dtemp, 14) * dtemp, 4);
    t3    = asr(asr(k[3] * dtemp, 18) * dtemp, 18) * dtemp;
    tcomp = asr((TEMP_REF << 15) - t1 - t2 - t3, 15);

    dtq    = asr(t1 + t2 + t3, 12);
    off1   = (k[5] - K5_OFS) * dtq;
    off2   = asr(asr(k[6] * dtq, 16) * dtq, 2);
    offset = asr(off1 + off2, 10) + ((k[4] + K4_OFS) << 4);

    s1    = asr((k[8] + K8_OFS) * dtq, 10);
    s2    = asr(asr(k[9] * dtq, 17) * dtq, 12);
    sdiff = ($signed(s2) >= $signed(s1)) ? (s2 - s1) : (s1 - s2);
    sgain = k[7] + K7_OFS;
    s3    = asr(sdiff, 11) * sgain;
    s4    = asr((sdiff & FRAC11) * sgain, 11);
    if ($signed(s1) >= $signed(s2)) sens = asr(32'd0 - s3 - s4, 11) + sgain;
    else sens = asr(s3 + s4, 11) + sgain;

    pa = asr((up - READING_MID) - offset, 3);
    pb = asr(sens, 11) * pa;
    pc = asr((sens & FRAC11) * pa, 11);
    pd = asr(pb + pc, 10);

    corr = asr(CORR_BIAS + k[12] * dtq, 3);
    q1   = asr(asr(corr * k[10], 17) * pd, 2);
    q2   = asr(asr(corr * k[11], 15) * pd, 18) * pd;
    pres = asr(q1 + q2, 15) + pd + SEA_LEVEL;

    r.temp_cd = tcomp[TEMP_W-1:0];
    r.pres_pa = pres;
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("baro_pressure_temp_compensation_top_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    comp_result_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_comp.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result temp %0d pres %0d", $time,
                 res_if.temperature_centideg, res_if.pressure_pa);
      end else begin
        exp_r = expected_comp.pop_front();
        results_checked++;
        if (res_if.temperature_centideg !== exp_r.temp_cd) begin
          mismatches++;
          $display("%0t: temperature_centideg expected %0d actual %0d", $time,
                   $signed(exp_r.temp_cd), res_if.temperature_centideg);
        end
        if (res_if.pressure_pa !== exp_r.pres_pa) begin
          mismatches++;
          $display("%0t: pressure_pa expected %0d actual %0d", $time,
                   $signed(exp_r.pres_pa), res_if.pressure_pa);
        end
      end
    end
  end

  task automatic send_reading(input logic [RAW_W-1:0] p_raw,
                              input logic [RAW_W-1:0] t_raw);
    while ($urandom_range(99) < src_idle_pct) begin
      raw_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    raw_if.valid           <= 1'b1;
    raw_if.raw_pressure    <= p_raw;
    raw_if.raw_temperature <= t_raw;
    do @(posedge clk_i); while (!raw_if.ready);
    expected_comp.push_back(compensate(p_raw, t_raw));
  endtask

  // hold off until every outstanding word has come back
  task automatic drain();
    raw_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_comp.size() != 0);
  endtask

  task automatic write_cal(input logic [1:0] index, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      REG_CAL_LOW:  cal_lo  = value;
      REG_CAL_MID:  cal_mid = value;
      REG_CAL_HIGH: cal_hi  = value[31:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_calibration(input logic [63:0] lo, input logic [63:0] mid,
                                  input logic [63:0] hi);
    drain();
    write_cal(REG_CAL_LOW, lo);
    write_cal(REG_CAL_MID, mid);
    write_cal(REG_CAL_HIGH, hi);
    cal_settings++;
  endtask

  task automatic test_reset_calibration();
    send_reading(24'h000000, 24'h000000);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'h800000, 24'h800000);
    send_reading(24'h000000, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'h000000);
  endtask

  task automatic test_register_map();
    load_calibration(CAL_LO_TYP, CAL_MID_TYP, {32'd0, CAL_HI_TYP});
    write_cal(CAL_UNUSED, '1);
    write_cal(REG_CAL_HIGH, {32'hFFFF_FFFF, CAL_HI_TYP});
    send_reading(24'h7E5A3C, 24'h8B1F20);
    send_reading(24'h6F0012, 24'h7A33C1);
    send_reading(24'h000000, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'h000000);
  endtask

  task automatic test_calibration_extremes();
    load_calibration('1, '1, '1);
    send_reading(24'h000000, 24'h000000);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'h000000, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'h000000);
    load_calibration({4{16'hAAAA}}, {4{16'hAAAA}}, {4{16'hAAAA}});
    send_reading(24'hAAAAAA, 24'h555555);
    send_reading(24'h555555, 24'hAAAAAA);
    load_calibration({4{16'h5555}}, {4{16'h5555}}, {4{16'h5555}});
    send_reading(24'h555555, 24'hAAAAAA);
    send_reading(24'hAAAAAA, 24'h555555);
  endtask

  task automatic test_random_readings(input int src_pct, input int snk_pct);
    logic [RAW_W-1:0] p_raw;
    logic [RAW_W-1:0] t_raw;
    logic [63:0]      jitter;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int s = 0; s < 2; s++) begin
      if (s == 0) begin
        load_calibration({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        jitter = {$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF;
        load_calibration(CAL_LO_TYP ^ jitter, CAL_MID_TYP ^ jitter,
                         {32'd0, CAL_HI_TYP ^ jitter[31:0]});
      end
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        if (i == ITEMS_PER_SETTING / 2) drain();
        if ($urandom_range(1)) begin
          p_raw = 24'($urandom);
          t_raw = 24'($urandom);
        end else begin
          p_raw = 24'(32'h780000 + $urandom_range(0, 24'h0FFFFF));
          t_raw = 24'(32'h780000 + $urandom_range(0, 24'h0FFFFF));
        end
        send_reading(p_raw, t_raw);
      end
    end
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    raw_if.valid           <= 1'b0;
    raw_if.raw_pressure    <= '0;
    raw_if.raw_temperature <= '0;
    cal_lo          = '0;
    cal_mid         = '0;
    cal_hi          = '0;
    src_idle_pct    = 29;
    snk_idle_pct    = 83;
    cal_settings    = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_calibration();
    test_register_map();
    test_calibration_extremes();
    test_random_readings(29, 83);
    test_random_readings(83, 29);
    test_random_readings(0, 0);

    drain();
    repeat (40) @(posedge clk_i);
    $display("Checked %0d compensated results over %0d calibration settings,",
             results_checked, cal_settings);
    $display("with sender and receiver stalls mixed, swapped and absent.");
    if (mismatches == 0 && expected_comp.size() == 0) begin
      $display("baro_pressure_temp_compensation_top_test OK");
    end else begin
      $display("baro_pressure_temp_compensation_top_test NOT OK");
    end
    $finish;
  end

endmodule
